// ----- rtl/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgr_pkg
// shared types and constants of the text console glyph renderer
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // glyph geometry
    localparam int GLYPH_ROWS = 16;
    localparam int GLYPH_COLS = 8;

    // saturated line width, pixel offset of a glyph's top row
    localparam int WIDTH_W = 14;
    localparam int PIX_W   = 26;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // control codes that only move the cursor
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // pixel formats
    localparam logic [1:0] FMT_RGBA32   = 2'd0;
    localparam logic [1:0] FMT_RGB24    = 2'd1;
    localparam logic [1:0] FMT_RGB565   = 2'd2;
    localparam logic [1:0] FMT_RESERVED = 2'd3;

    // configuration register indexes
    typedef enum logic [2:0]
    {
        REG_FRAME_BASE   = 3'd0,
        REG_LINE_WIDTH   = 3'd1,
        REG_PIXEL_FORMAT = 3'd2,
        REG_TEXT_COLOR   = 3'd3,
        REG_BACK_COLOR   = 3'd4
    } reg_idx_t;

    typedef enum logic
    {
        CMD_LOAD,
        CMD_GLYPH
    } cmd_t;

    // one queued command; idx is the font word index or the char code
    typedef struct packed
    {
        cmd_t               cmd;
        logic [9:0]         idx;
        logic [31:0]        word;
        logic [PIX_W-1:0]   pix;
    } item_t;

    // configuration as seen by the back end
    typedef struct packed
    {
        logic [31:0]        frame_base;
        logic [WIDTH_W-1:0] width_sat;
        logic [1:0]         pixel_format;
        logic [31:0]        text_color;
        logic [31:0]        back_color;
    } cfg_t;

endpackage

// ----- rtl/tcgr_ifs.sv -----
// ----------------------------------------------------------------------------
// tcgr interfaces
// valid/ready channels for character requests and pixel rows
// ----------------------------------------------------------------------------
interface tcgr_char_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  char_code;
    logic [9:0]  font_addr;
    logic [31:0] font_word;

    modport source
    (
        output valid, req_type, char_code, font_addr, font_word,
        input  ready
    );
    modport sink
    (
        input  valid, req_type, char_code, font_addr, font_word,
        output ready
    );
endinterface

interface tcgr_row_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_address;
    logic [31:0] pixel_0;
    logic [31:0] pixel_1;
    logic [31:0] pixel_2;
    logic [31:0] pixel_3;
    logic [31:0] pixel_4;
    logic [31:0] pixel_5;
    logic [31:0] pixel_6;
    logic [31:0] pixel_7;
    logic        last;

    modport source
    (
        output valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, last,
        input  ready
    );
    modport sink
    (
        input  valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, last,
        output ready
    );
endinterface

// ----- rtl/tcgr_front.sv -----
// ----------------------------------------------------------------------------
// tcgr_front
// accepts requests, keeps the cursor, turns requests into queued commands
// ----------------------------------------------------------------------------
module tcgr_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tcgr_pkg::WIDTH_W-1:0] width_sat,
    tcgr_char_if.sink                    char_in,
    input  logic                         q_ready,
    output logic                         q_push,
    output tcgr_pkg::item_t              q_item
);
    import tcgr_pkg::*;

    logic             stage_valid_reg, stage_valid_next;
    cmd_t             stage_cmd_reg, stage_cmd_next;
    logic [9:0]       stage_idx_reg, stage_idx_next;
    logic [31:0]      stage_word_reg, stage_word_next;
    logic [PIX_W-1:0] stage_prod_reg, stage_prod_next;
    logic [7:0]       stage_col_reg, stage_col_next;
    logic [7:0]       col_reg, col_next;
    logic [7:0]       row_reg, row_next;
    logic             accept;
    logic [11:0]      pix_row;

    assign q_push        = stage_valid_reg && q_ready;
    assign char_in.ready = !stage_valid_reg || q_ready;
    assign accept        = char_in.valid && char_in.ready;
    assign pix_row       = {row_reg, 4'b0000};

    assign q_item.cmd  = stage_cmd_reg;
    assign q_item.idx  = stage_idx_reg;
    assign q_item.word = stage_word_reg;
    assign q_item.pix  = stage_prod_reg + PIX_W'({stage_col_reg, 3'b000});

    always_comb
    begin
        stage_valid_next = stage_valid_reg && !q_push;
        stage_cmd_next   = stage_cmd_reg;
        stage_idx_next   = stage_idx_reg;
        stage_word_next  = stage_word_reg;
        stage_prod_next  = stage_prod_reg;
        stage_col_next   = stage_col_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        if (accept)
        begin
            if (!char_in.req_type)
            begin
                stage_valid_next = 1'b1;
                stage_cmd_next   = CMD_LOAD;
                stage_idx_next   = char_in.font_addr;
                stage_word_next  = char_in.font_word;
            end
            else if (char_in.char_code == CHAR_CR)
            begin
                col_next = '0;
            end
            else if (char_in.char_code == CHAR_LF)
            begin
                col_next = '0;
                row_next = row_reg + 8'd1;
            end
            else
            begin
                stage_valid_next = 1'b1;
                stage_cmd_next   = CMD_GLYPH;
                stage_idx_next   = {2'b00, char_in.char_code};
                stage_prod_next  = PIX_W'(pix_row) * PIX_W'(width_sat);
                stage_col_next   = col_reg;
                col_next         = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_cmd_reg   <= CMD_LOAD;
            stage_idx_reg   <= '0;
            stage_word_reg  <= '0;
            stage_prod_reg  <= '0;
            stage_col_reg   <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            stage_cmd_reg   <= stage_cmd_next;
            stage_idx_reg   <= stage_idx_next;
            stage_word_reg  <= stage_word_next;
            stage_prod_reg  <= stage_prod_next;
            stage_col_reg   <= stage_col_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

endmodule

// ----- rtl/tcgr_queue.sv -----
// ----------------------------------------------------------------------------
// tcgr_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module tcgr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tcgr_pkg::item_t push_item,
    output logic            ready,
    output logic            valid,
    input  logic            pop,
    output tcgr_pkg::item_t head
);
    import tcgr_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/tcgr_back.sv -----
// ----------------------------------------------------------------------------
// tcgr_back
// font store and row generator, one pixel row per cycle while row_out is not stalled
// ----------------------------------------------------------------------------
module tcgr_back #(
    parameter int FONT_WORDS = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tcgr_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  tcgr_pkg::item_t q_item,
    output logic            q_pop,
    tcgr_row_if.source      row_out
);
    import tcgr_pkg::*;

    localparam int          FONT_AW    = $clog2(FONT_WORDS);
    localparam logic [10:0] FONT_LIMIT = 11'(FONT_WORDS);

    typedef enum logic
    {
        B_IDLE,
        B_EMIT
    } state_t;

    logic [31:0] font_mem [FONT_WORDS];
    logic [31:0] rd_data_reg;
    logic        rd_zero_reg;

    state_t      state_reg, state_next;
    logic [3:0]  row_cnt_reg, row_cnt_next;
    logic [7:0]  glyph_reg, glyph_next;
    logic [31:0] addr_reg, addr_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [31:0] out_pix_reg [GLYPH_COLS];
    logic [31:0] out_pix_next [GLYPH_COLS];
    logic        out_last_reg, out_last_next;

    logic        out_free, emit_go, row_done, take, load_go, glyph_go, quarter_go;
    logic        rd_en, wr_en, rd_ok;
    logic [9:0]  rd_idx;
    logic [31:0] cur_word, fg, bg, start_off;
    logic [15:0] stride;
    logic [7:0]  row_bits;

    function automatic logic [31:0] convert_color(input logic [1:0] fmt,
                                                  input logic [31:0] c);
        logic [31:0] res;
        case (fmt)
            FMT_RGB24:  res = {8'h00, c[23:0]};
            FMT_RGB565: res = {16'h0000, c[23:19], c[15:10], c[7:3]};
            default:    res = c;
        endcase
        return res;
    endfunction

    assign out_free   = !out_valid_reg || row_out.ready;
    assign emit_go    = (state_reg == B_EMIT) && out_free;
    assign row_done   = emit_go && (row_cnt_reg == 4'(GLYPH_ROWS - 1));
    assign take       = q_valid && ((state_reg == B_IDLE) || row_done);
    assign load_go    = take && (q_item.cmd == CMD_LOAD);
    assign glyph_go   = take && (q_item.cmd == CMD_GLYPH);
    assign quarter_go = emit_go && (row_cnt_reg[1:0] == 2'b11) && !row_done;
    assign q_pop      = take;

    // word index of the next quarter glyph, or of a new glyph's first quarter
    assign rd_en  = glyph_go || quarter_go;
    assign rd_idx = glyph_go ? {q_item.idx[7:0], 2'b00}
                             : {glyph_reg, row_cnt_reg[3:2] + 2'd1};
    assign rd_ok  = {1'b0, rd_idx} < FONT_LIMIT;
    assign wr_en  = load_go && ({1'b0, q_item.idx} < FONT_LIMIT);

    assign cur_word = rd_zero_reg ? 32'h0 : rd_data_reg;
    assign fg       = convert_color(cfg.pixel_format, cfg.text_color);
    assign bg       = convert_color(cfg.pixel_format, cfg.back_color);

    always_comb
    begin
        case (row_cnt_reg[1:0])
            2'd0:    row_bits = cur_word[31:24];
            2'd1:    row_bits = cur_word[23:16];
            2'd2:    row_bits = cur_word[15:8];
            default: row_bits = cur_word[7:0];
        endcase
    end

    // byte offset of the glyph's top row and byte stride between rows
    always_comb
    begin
        case (cfg.pixel_format)
            FMT_RGB24:
            begin
                start_off = 32'({q_item.pix, 1'b0}) + 32'(q_item.pix);
                stride    = 16'({cfg.width_sat, 1'b0}) + 16'(cfg.width_sat);
            end
            FMT_RGB565:
            begin
                start_off = 32'({q_item.pix, 1'b0});
                stride    = 16'({cfg.width_sat, 1'b0});
            end
            default:
            begin
                start_off = 32'({q_item.pix, 2'b00});
                stride    = 16'({cfg.width_sat, 2'b00});
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        glyph_next     = glyph_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !row_out.ready;
        out_addr_next  = out_addr_reg;
        out_last_next  = out_last_reg;
        for (int i = 0; i < GLYPH_COLS; i++)
        begin
            out_pix_next[i] = out_pix_reg[i];
        end

        if (emit_go)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = addr_reg;
            out_last_next  = row_done;
            for (int i = 0; i < GLYPH_COLS; i++)
            begin
                out_pix_next[i] = row_bits[GLYPH_COLS - 1 - i] ? fg : bg;
            end
            addr_next    = addr_reg + 32'(stride);
            row_cnt_next = row_cnt_reg + 4'd1;
            if (row_done)
            begin
                state_next = B_IDLE;
            end
        end

        if (glyph_go)
        begin
            state_next   = B_EMIT;
            row_cnt_next = '0;
            glyph_next   = q_item.idx[7:0];
            addr_next    = cfg.frame_base + start_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            row_cnt_reg   <= '0;
            glyph_reg     <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < GLYPH_COLS; i++)
            begin
                out_pix_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            glyph_reg     <= glyph_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            out_addr_reg  <= out_addr_next;
            out_last_reg  <= out_last_next;
            for (int i = 0; i < GLYPH_COLS; i++)
            begin
                out_pix_reg[i] <= out_pix_next[i];
            end
        end
    end

    // font store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            font_mem[q_item.idx[FONT_AW-1:0]] <= q_item.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= font_mem[rd_idx[FONT_AW-1:0]];
            rd_zero_reg <= !rd_ok;
        end
    end

    assign row_out.valid       = out_valid_reg;
    assign row_out.row_address = out_addr_reg;
    assign row_out.pixel_0     = out_pix_reg[0];
    assign row_out.pixel_1     = out_pix_reg[1];
    assign row_out.pixel_2     = out_pix_reg[2];
    assign row_out.pixel_3     = out_pix_reg[3];
    assign row_out.pixel_4     = out_pix_reg[4];
    assign row_out.pixel_5     = out_pix_reg[5];
    assign row_out.pixel_6     = out_pix_reg[6];
    assign row_out.pixel_7     = out_pix_reg[7];
    assign row_out.last        = out_last_reg;

endmodule

// ----- rtl/text_console_glyph_renderer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core
// 8x16 bitmap font text console: loads a font store, renders characters
// into framebuffer pixel rows with their byte addresses
// ----------------------------------------------------------------------------
//
//  port        dir  handshake        carries
//  ----------  ---  ---------------  ---------------------------------------
//  char_in     in   valid/ready      font word load or one character
//  row_out     out  valid/ready      row address, eight pixels, last flag
//  cfg_*       in   cfg_we only      register index and data, no read-back
//
//  a printable character gives 16 rows, one row per cycle while row_out is ready;
//  back-to-back characters are rendered one after another by the single row generator
//  font loads end in the back end, cr and lf in the front; glyphs pass front, queue, back
//  reset clears cursor and queue, sets config to defaults; the font store is not cleared
//  a stalled row_out holds the back end, the queue then fills and stalls
//  char_in; cr and lf pass while the front stage is free
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core #(
    parameter int FONT_WORDS     = 1024,
    parameter int MAX_LINE_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    tcgr_char_if.sink   char_in,
    tcgr_row_if.source  row_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tcgr_pkg::*;

    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(MAX_LINE_WIDTH);

    // configuration registers
    logic [31:0]        frame_base_reg;
    logic [12:0]        line_width_reg;
    logic [1:0]         pixel_format_reg;
    logic [31:0]        text_color_reg;
    logic [31:0]        back_color_reg;

    logic [WIDTH_W-1:0] width_sat;
    cfg_t               cfg;

    // front to queue, queue to back
    logic               q_push;
    logic               q_ready;
    item_t              q_push_item;
    logic               q_valid;
    logic               q_pop;
    item_t              q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg   <= 32'h0000_0000;
            line_width_reg   <= 13'd640;
            pixel_format_reg <= FMT_RGBA32;
            text_color_reg   <= 32'hFFFF_FFFF;
            back_color_reg   <= 32'h0000_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[12:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                REG_TEXT_COLOR:   text_color_reg   <= cfg_data;
                REG_BACK_COLOR:   back_color_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // row stride in pixels, clipped to the widest supported line
    assign width_sat = (WIDTH_W'(line_width_reg) > WIDTH_LIMIT) ? WIDTH_LIMIT
                                                                : WIDTH_W'(line_width_reg);

    assign cfg.frame_base   = frame_base_reg;
    assign cfg.width_sat    = width_sat;
    assign cfg.pixel_format = pixel_format_reg;
    assign cfg.text_color   = text_color_reg;
    assign cfg.back_color   = back_color_reg;

    // front: cursor, cr/lf handling, glyph row offset multiply
    tcgr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .width_sat (width_sat),
        .char_in   (char_in),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    // two-entry queue keeps font loads and glyphs in order
    tcgr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .ready     (q_ready),
        .valid     (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    // back: font store, row generation, output register
    tcgr_back #(
        .FONT_WORDS (FONT_WORDS)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .row_out (row_out)
    );

    // back end never takes from an empty queue
    a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // front end never pushes into a full queue
    a_push_ready : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("queue pushed while full");

    // a pop without a push always frees a slot
    a_pop_frees : assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> q_ready)
        else $error("queue still full after pop");

endmodule

// ----- tb/sv/text_console_glyph_renderer_core_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core_tb
// loads glyphs into the font store, sends characters, carriage returns and
// line feeds under several register settings, and checks every pixel row
// against rows worked out here from a private copy of font, cursor and
// registers; both channels idle at random and the row side holds off once
// for a long stretch
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tcgr_pkg::*;

    localparam int MAX_LINE_WIDTH  = 4096;
    localparam int FONT_WORDS      = 1024;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct
    {
        cmd_t        kind;
        logic [7:0]  code;
        logic [9:0]  addr;
        logic [31:0] word;
    } console_req_t;

    typedef struct packed
    {
        logic [31:0]      row_address;
        logic [7:0][31:0] pix;
        logic             last;
    } pixel_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    tcgr_char_if char_bus();
    tcgr_row_if  row_bus();

    text_console_glyph_renderer_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .row_out   (row_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow of the block: font, cursor and registers
    logic [31:0] font_shadow [0:FONT_WORDS-1];
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    logic [31:0] cfg_frame_base;
    logic [12:0] cfg_line_width;
    logic [1:0]  cfg_pixel_format;
    logic [31:0] cfg_text_color;
    logic [31:0] cfg_back_color;

    // items waiting to be offered, rows waiting to come out
    console_req_t pending_requests [$];
    pixel_row_t   expected_rows [$];
    console_req_t offered_req;

    // which glyphs are fully loaded once the pending items are through
    logic [3:0] quarters_planned [0:255];
    bit         glyph_listed [0:255];
    logic [7:0] ready_codes [$];

    // idling and hold-off controls, written by the sequence on falling edges
    int src_idle_pct;
    int snk_idle_pct;
    bit hold_request;
    int src_gap;
    int snk_gap;
    int hold_left;

    int mismatch_count;
    int cycle_count;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // colour in the selected format, unused high bits zero
    function automatic logic [31:0] format_color(input logic [31:0] c);
        case (cfg_pixel_format)
            FMT_RGB24:  return {8'h00, c[23:0]};
            FMT_RGB565: return {16'h0000, c[23:19], c[15:10], c[7:3]};
            default:    return c;
        endcase
    endfunction

    // sixteen rows of one glyph at the cursor, then the column moves on
    task automatic render_glyph_rows(input logic [7:0] code);
        logic [31:0] stride;
        logic [31:0] bpp;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [31:0] word;
        logic [7:0]  bits;
        logic [31:0] y;
        logic [3:0]  r4;
        pixel_row_t  row;
        stride = (cfg_line_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : cfg_line_width;
        case (cfg_pixel_format)
            FMT_RGB24:  bpp = 3;
            FMT_RGB565: bpp = 2;
            default:    bpp = 4;
        endcase
        fg = format_color(cfg_text_color);
        bg = format_color(cfg_back_color);
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            r4   = 4'(r);
            word = font_shadow[{code, r4[3:2]}];
            bits = word[31 - 8 * r4[1:0] -: 8];
            y    = {cursor_row, 4'b0000} + r;
            row.row_address = cfg_frame_base + (y * stride + {cursor_col, 3'b000}) * bpp;
            for (int i = 0; i < GLYPH_COLS; i++)
                row.pix[i] = bits[7 - i] ? fg : bg;
            row.last = (r == GLYPH_ROWS - 1);
            expected_rows.push_back(row);
        end
        cursor_col = cursor_col + 8'd1;
    endtask

    // effect of one accepted item on the shadow
    task automatic apply_console_request(input console_req_t q);
        if (q.kind == CMD_LOAD)
            font_shadow[q.addr] = q.word;
        else if (q.code == CHAR_CR)
            cursor_col = 8'd0;
        else if (q.code == CHAR_LF)
        begin
            cursor_col = 8'd0;
            cursor_row = cursor_row + 8'd1;
        end
        else
            render_glyph_rows(q.code);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name,
                     want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_pixel_row();
        pixel_row_t want;
        if (expected_rows.size() == 0)
        begin
            $display("%0t: unexpected row, expected none actual address %h",
                     $realtime, row_bus.row_address);
            mismatch_count++;
        end
        else
        begin
            want = expected_rows.pop_front();
            compare_field("row_address", want.row_address, row_bus.row_address);
            compare_field("pixel_0", want.pix[0], row_bus.pixel_0);
            compare_field("pixel_1", want.pix[1], row_bus.pixel_1);
            compare_field("pixel_2", want.pix[2], row_bus.pixel_2);
            compare_field("pixel_3", want.pix[3], row_bus.pixel_3);
            compare_field("pixel_4", want.pix[4], row_bus.pixel_4);
            compare_field("pixel_5", want.pix[5], row_bus.pixel_5);
            compare_field("pixel_6", want.pix[6], row_bus.pixel_6);
            compare_field("pixel_7", want.pix[7], row_bus.pixel_7);
            compare_field("last", 32'(want.last), 32'(row_bus.last));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers pending items, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.valid     <= 1'b0;
            char_bus.req_type  <= 1'b0;
            char_bus.char_code <= 8'd0;
            char_bus.font_addr <= 10'd0;
            char_bus.font_word <= 32'd0;
            src_gap = 0;
        end
        else
        begin
            if (char_bus.valid && char_bus.ready)
                apply_console_request(offered_req);
            // a new item may go out once the current one is taken
            if (!char_bus.valid || char_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    char_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 && src_idle_pct != 0 &&
                         $urandom_range(0, 99) < src_idle_pct)
                begin
                    // start an idle burst, src_gap holds the rest of it
                    src_gap = $urandom_range(0, 4);
                    char_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    offered_req = pending_requests.pop_front();
                    char_bus.req_type  <= offered_req.kind;
                    char_bus.char_code <= offered_req.code;
                    char_bus.font_addr <= offered_req.addr;
                    char_bus.font_word <= offered_req.word;
                    char_bus.valid     <= 1'b1;
                end
                else
                    char_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks accepted rows, stalls at random, holds off once
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bus.ready <= 1'b0;
            snk_gap   = 0;
            hold_left = 0;
        end
        else
        begin
            if (row_bus.valid && row_bus.ready)
                check_pixel_row();
            if (hold_request)
            begin
                hold_left    = PRESSURE_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                // long hold-off so the block backs up into char_in
                hold_left--;
                row_bus.ready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                row_bus.ready <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                snk_gap = $urandom_range(0, 4);
                row_bus.ready <= 1'b0;
            end
            else
                row_bus.ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [31:0] random_font_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // load item; a glyph other than cr or lf becomes printable once all four quarters are queued
    task automatic queue_load(input logic [9:0] addr, input logic [31:0] word);
        console_req_t q;
        logic [7:0] g;
        q.kind = CMD_LOAD;
        q.code = 8'($urandom_range(0, 255));
        q.addr = addr;
        q.word = word;
        pending_requests.push_back(q);
        g = addr[9:2];
        quarters_planned[g][addr[1:0]] = 1'b1;
        if (quarters_planned[g] == 4'hF && !glyph_listed[g] &&
            g != CHAR_LF && g != CHAR_CR)
        begin
            glyph_listed[g] = 1'b1;
            ready_codes.push_back(g);
        end
    endtask

    // character item, font fields carry noise
    task automatic queue_char(input logic [7:0] code);
        console_req_t q;
        q.kind = CMD_GLYPH;
        q.code = code;
        q.addr = 10'($urandom_range(0, 1023));
        q.word = $urandom;
        pending_requests.push_back(q);
    endtask

    // whole glyph, quarters in a rotated order
    task automatic queue_glyph_load(input logic [7:0] g);
        int start;
        start = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++)
            queue_load({g, 2'((start + k) % 4)}, random_font_word());
    endtask

    function automatic logic [7:0] pick_ready_code();
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    // mostly printable glyphs, with glyph loads, stray words, cr and lf
    task automatic queue_mixed(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                queue_glyph_load(8'($urandom_range(0, 255)));
            else if (pick < 18)
                queue_load(10'($urandom_range(0, 1023)), random_font_word());
            else if (pick < 25)
                queue_char(CHAR_CR);
            else if (pick < 32)
                queue_char(CHAR_LF);
            else
                queue_char(pick_ready_code());
        end
    endtask

    // ------------------------------------------------------------------------
    // config port and phase boundaries
    // ------------------------------------------------------------------------

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FRAME_BASE:   cfg_frame_base   = data;
            REG_LINE_WIDTH:   cfg_line_width   = data[12:0];
            REG_PIXEL_FORMAT: cfg_pixel_format = data[1:0];
            REG_TEXT_COLOR:   cfg_text_color   = data;
            REG_BACK_COLOR:   cfg_back_color   = data;
            default: ;
        endcase
    endtask

    task automatic program_console(input logic [31:0] base, input logic [31:0] width,
                                   input logic [1:0] fmt, input logic [31:0] fg,
                                   input logic [31:0] bg);
        write_register(REG_FRAME_BASE, base);
        write_register(REG_LINE_WIDTH, width);
        write_register(REG_PIXEL_FORMAT, 32'(fmt));
        write_register(REG_TEXT_COLOR, fg);
        write_register(REG_BACK_COLOR, bg);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // all items taken, all rows out, then room for a trailing font load
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || char_bus.valid || expected_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] lf_count;

        // every input known from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_FRAME_BASE;
        cfg_data           = 32'd0;
        char_bus.valid     = 1'b0;
        char_bus.req_type  = 1'b0;
        char_bus.char_code = 8'd0;
        char_bus.font_addr = 10'd0;
        char_bus.font_word = 32'd0;
        row_bus.ready      = 1'b0;
        src_idle_pct       = 20;
        snk_idle_pct       = 20;
        hold_request       = 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;

        // shadow at its reset values
        cursor_col       = 8'd0;
        cursor_row       = 8'd0;
        cfg_frame_base   = 32'd0;
        cfg_line_width   = 13'd640;
        cfg_pixel_format = FMT_RGBA32;
        cfg_text_color   = 32'hFFFF_FFFF;
        cfg_back_color   = 32'd0;
        for (int g = 0; g < 256; g++)
        begin
            quarters_planned[g] = 4'h0;
            glyph_listed[g]     = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: lowest and highest glyph, font address extremes, all control
        // codes, cr and lf back to back, a rewritten font word; reset registers
        queue_load(10'd0, 32'hFFFF_FFFF);
        queue_load(10'd1, 32'h0000_0000);
        queue_load(10'd2, 32'hAA55_AA55);
        queue_load(10'd3, 32'h8142_2418);
        queue_load(10'd1020, 32'h0000_0000);
        queue_load(10'd1021, 32'hFFFF_FFFF);
        queue_load(10'd1022, 32'h55AA_55AA);
        queue_load(10'd1023, 32'h1824_4281);
        queue_char(8'd0);
        queue_char(8'd255);
        queue_char(CHAR_CR);
        queue_char(8'd255);
        queue_char(CHAR_LF);
        queue_char(8'd0);
        queue_char(CHAR_LF);
        queue_char(CHAR_LF);
        queue_char(8'd255);
        queue_char(CHAR_CR);
        queue_char(CHAR_CR);
        queue_char(CHAR_LF);
        queue_load(10'd1021, 32'h0F0F_F0F0);
        queue_char(8'd255);
        queue_char(8'd0);
        wait_drained();

        // 24-bit colour, shifted base
        program_console(32'h1000_0000, 32'd640, FMT_RGB24, $urandom, $urandom);
        queue_mixed(12);
        wait_drained();

        // rgb565, widest line, base near the top so addresses wrap;
        // the row side holds off for a long stretch at the start
        program_console(32'hFFFF_FF00, 32'd4096, FMT_RGB565, 32'hFFFF_FFFF, 32'h0);
        src_idle_pct = 10;
        snk_idle_pct = 30;
        hold_request = 1'b1;
        queue_mixed(20);
        wait_drained();

        // reserved format acts as 32-bit, line width above the maximum saturates
        program_console(32'h0, 32'd8191, FMT_RESERVED, $urandom, $urandom);
        src_idle_pct = 40;
        snk_idle_pct = 0;
        queue_mixed(8);
        wait_drained();

        // zero line width, all rows of a glyph share one address; no idling
        program_console($urandom, 32'd0, FMT_RGBA32, 32'h0, 32'hFFFF_FFFF);
        src_idle_pct = 0;
        queue_mixed(6);
        wait_drained();

        // line feeds up to the last row on the widest line, then glyphs across
        // the row wrap
        program_console($urandom, 32'd4096, FMT_RGB565, $urandom, $urandom);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        lf_count = 8'd254 - cursor_row;
        repeat (lf_count)
        begin
            queue_char(CHAR_LF);
            if ($urandom_range(0, 31) == 0)
                queue_char(pick_ready_code());
        end
        repeat (3)
        begin
            queue_char(pick_ready_code());
            queue_char(CHAR_LF);
        end
        queue_char(pick_ready_code());
        wait_drained();

        // last part runs without idling on either side
        program_console($urandom, 32'($urandom_range(2, 4095)), FMT_RGBA32, $urandom,
                        $urandom);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_mixed(10);
        wait_drained();

        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcgr_pkg.sv
rtl/tcgr_ifs.sv
rtl/tcgr_front.sv
rtl/tcgr_queue.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer_core.sv
tb/sv/text_console_glyph_renderer_core_tb.sv
